/* hdl/tsi_pkg.sv */
// Shared types, widths and byte constants for the text sequence indexer.
// Used by tsi_parse, tsi_out_fifo and text_sequence_indexer_unit; no dependencies.
`default_nettype none

package tsi_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int KEY_BITS    = 32;
    localparam int CNT_BITS    = 32;
    localparam int OUT_BITS    = 32;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    localparam logic [7:0] MARK_B0   = 8'hEF;
    localparam logic [7:0] MARK_B1   = 8'hBB;
    localparam logic [7:0] MARK_B2   = 8'hBF;
    localparam logic [7:0] NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_PIPE = 8'h7C;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_NO_ID = 1'b1;

    typedef struct packed {
        logic [OUT_BITS-1:0] key;
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] size;
        logic [OUT_BITS-1:0] lines;
        logic                status;
        logic                last_run;
    } t_result;

    // up to two results per byte; r0 fills first
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_emit;

    function automatic logic [7:0] mark_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = MARK_B0;
            2'd1:    b = MARK_B1;
            default: b = MARK_B2;
        endcase
        return b;
    endfunction

    function automatic t_result make_result(
        input logic [KEY_BITS-1:0]    key,
        input logic [OFFSET_BITS-1:0] start,
        input logic [OFFSET_BITS-1:0] size,
        input logic [CNT_BITS-1:0]    lines,
        input logic                   status
    );
        logic [63:0] k64;
        logic [63:0] s64;
        logic [63:0] z64;
        logic [63:0] l64;
        t_result     r;
        k64        = 64'(key);
        s64        = 64'(start);
        z64        = 64'(size);
        l64        = 64'(lines);
        r.key      = k64[OUT_BITS-1:0];
        r.start    = s64[OUT_BITS-1:0];
        r.size     = z64[OUT_BITS-1:0];
        r.lines    = l64[OUT_BITS-1:0];
        r.status   = status;
        r.last_run = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/tsi_parse.sv */
// Per-byte parser: mark check, lines/ids mode tracking and record generation.
// Depends on tsi_pkg for widths, byte constants and the result types.
`default_nettype none

module tsi_parse (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_advance,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    input  wire logic          i_use_ids,
    output tsi_pkg::t_emit     o_emit
);

    localparam int OW = tsi_pkg::OFFSET_BITS;
    localparam int KW = tsi_pkg::KEY_BITS;
    localparam int CW = tsi_pkg::CNT_BITS;

    localparam logic [2:0] MODE_MARK     = 3'd0;
    localparam logic [2:0] MODE_LINES    = 3'd1;
    localparam logic [2:0] MODE_FIRST_ID = 3'd2;
    localparam logic [2:0] MODE_IDS      = 3'd3;
    localparam logic [2:0] MODE_HALTED   = 3'd4;

    logic [2:0]    r_mode,      n_mode;
    logic [1:0]    r_held,      n_held;
    logic [OW-1:0] r_pos,       n_pos;
    logic [OW-1:0] r_rec_start, n_rec_start;
    logic [KW-1:0] r_cur_key,   n_cur_key;
    logic [KW-1:0] r_id_acc,    n_id_acc;
    logic          r_id_seen,   n_id_seen;
    logic          r_at_head,   n_at_head;
    logic [CW-1:0] r_lines,     n_lines;
    logic [KW-1:0] r_line_idx,  n_line_idx;
    logic [OW-1:0] r_head_off,  n_head_off;

    logic                is_nl;
    logic                is_digit;
    logic [KW+3:0]       acc_wide;
    logic [KW-1:0]       acc_next;
    logic [KW-1:0]       line_idx_inc;

    logic                do_start;
    logic                do_parse;
    logic [2:0]          p_mode;
    logic [OW-1:0]       p_pos;
    logic [OW-1:0]       p_nxt;
    logic [OW-1:0]       p_rec;
    logic [OW-1:0]       p_head;

    logic                sk_en;
    logic [KW-1:0]       sk_key;
    logic [OW-1:0]       sk_rec;
    logic [CW-1:0]       sk_lines;
    logic [CW-1:0]       sk_lines_inc;

    logic                va;
    logic                vb;
    tsi_pkg::t_result    res_a;
    tsi_pkg::t_result    res_b;

    assign is_nl    = (i_byte == tsi_pkg::NEWLINE);
    assign is_digit = (i_byte >= tsi_pkg::CHAR_ZERO) && (i_byte <= tsi_pkg::CHAR_NINE);

    // times ten plus digit, saturating at all ones
    always_comb begin
        acc_wide = ({4'b0, r_id_acc} << 3) + ({4'b0, r_id_acc} << 1)
                 + (KW+4)'(i_byte - tsi_pkg::CHAR_ZERO);
        if (acc_wide > {4'b0, tsi_pkg::KEY_MAX}) begin
            acc_next = tsi_pkg::KEY_MAX;
        end else begin
            acc_next = acc_wide[KW-1:0];
        end
    end

    assign line_idx_inc = (r_line_idx != tsi_pkg::KEY_MAX) ? r_line_idx + KW'(1) : r_line_idx;

    always_comb begin
        n_mode      = r_mode;
        n_held      = r_held;
        n_pos       = r_pos;
        n_rec_start = r_rec_start;
        n_cur_key   = r_cur_key;
        n_id_acc    = r_id_acc;
        n_id_seen   = r_id_seen;
        n_at_head   = r_at_head;
        n_lines     = r_lines;
        n_line_idx  = r_line_idx;
        n_head_off  = r_head_off;

        do_start     = 1'b0;
        do_parse     = 1'b0;
        p_mode       = r_mode;
        p_pos        = r_pos;
        p_rec        = r_rec_start;
        p_head       = r_head_off;
        sk_en        = 1'b0;
        sk_key       = r_cur_key;
        sk_rec       = r_rec_start;
        sk_lines     = r_lines;
        sk_lines_inc = r_lines;
        va           = 1'b0;
        vb           = 1'b0;
        res_a        = '0;
        res_b        = '0;

        // file state is at its reset values while the mark is checked
        unique case (r_mode)
            MODE_MARK: begin
                if (r_held == 2'd3) begin
                    p_pos    = OW'(3);
                    do_start = 1'b1;
                end else if (i_byte == tsi_pkg::mark_byte(r_held) && !i_last) begin
                    n_held = r_held + 2'd1;
                end else if (r_held == 2'd0) begin
                    p_pos    = '0;
                    do_start = 1'b1;
                end else if (i_use_ids) begin
                    // replayed EF is no digit: missing first id
                    n_held = 2'd0;
                    vb     = 1'b1;
                    res_b  = tsi_pkg::make_result('0, '0, '0, '0, tsi_pkg::STATUS_NO_ID);
                    n_mode = MODE_HALTED;
                end else begin
                    // replayed mark bytes are plain line content
                    n_held   = 2'd0;
                    p_pos    = OW'(r_held);
                    p_mode   = MODE_LINES;
                    p_rec    = '0;
                    do_parse = 1'b1;
                end
            end
            default: begin
                do_parse = 1'b1;
            end
        endcase

        if (do_start) begin
            do_parse = 1'b1;
            n_held   = 2'd0;
            p_rec    = p_pos;
            p_head   = p_pos;
            p_mode   = (!i_use_ids || i_byte == tsi_pkg::CHAR_PIPE) ? MODE_LINES
                                                                     : MODE_FIRST_ID;
        end

        p_nxt = p_pos + OW'(1);

        if (do_parse) begin
            n_pos       = p_nxt;
            n_mode      = p_mode;
            n_rec_start = p_rec;
            n_head_off  = p_head;
            unique case (p_mode)
                MODE_LINES: begin
                    if (is_nl || i_last) begin
                        vb    = 1'b1;
                        res_b = tsi_pkg::make_result(r_line_idx, p_rec, p_nxt - p_rec,
                                                     CW'(1), tsi_pkg::STATUS_OK);
                    end
                    if (is_nl) begin
                        n_line_idx  = line_idx_inc;
                        n_rec_start = p_nxt;
                    end
                end
                MODE_FIRST_ID: begin
                    if (is_digit) begin
                        n_id_acc  = acc_next;
                        n_id_seen = 1'b1;
                        if (i_last) begin
                            vb     = 1'b1;
                            res_b  = tsi_pkg::make_result('0, p_rec, '0, '0,
                                                          tsi_pkg::STATUS_NO_ID);
                            n_mode = MODE_HALTED;
                        end
                    end else if (!r_id_seen) begin
                        vb     = 1'b1;
                        res_b  = tsi_pkg::make_result('0, p_rec, '0, '0, tsi_pkg::STATUS_NO_ID);
                        n_mode = MODE_HALTED;
                    end else begin
                        n_mode   = MODE_IDS;
                        sk_en    = 1'b1;
                        sk_key   = r_id_acc;
                        sk_rec   = p_rec;
                        sk_lines = r_lines;
                    end
                end
                MODE_IDS: begin
                    if (r_at_head && is_digit) begin
                        n_id_acc  = acc_next;
                        n_id_seen = 1'b1;
                        if (i_last) begin
                            vb    = 1'b1;
                            res_b = tsi_pkg::make_result(r_cur_key, p_rec, p_nxt - p_rec,
                                                         r_lines, tsi_pkg::STATUS_OK);
                        end
                    end else begin
                        sk_en    = 1'b1;
                        sk_key   = r_cur_key;
                        sk_rec   = p_rec;
                        sk_lines = r_lines;
                        // a differing id closes the open group at the line head
                        if (r_at_head && r_id_seen && r_id_acc != r_cur_key) begin
                            va       = 1'b1;
                            res_a    = tsi_pkg::make_result(r_cur_key, p_rec, p_head - p_rec,
                                                            r_lines, tsi_pkg::STATUS_OK);
                            sk_key   = r_id_acc;
                            sk_rec   = p_head;
                            sk_lines = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (sk_en) begin
            if ((is_nl || i_last) && sk_lines != tsi_pkg::CNT_MAX) begin
                sk_lines_inc = sk_lines + CW'(1);
            end else begin
                sk_lines_inc = sk_lines;
            end
            n_lines     = sk_lines_inc;
            n_cur_key   = sk_key;
            n_rec_start = sk_rec;
            n_at_head   = is_nl;
            if (is_nl) begin
                n_head_off = p_nxt;
                n_id_acc   = '0;
                n_id_seen  = 1'b0;
            end
            if (i_last) begin
                vb    = 1'b1;
                res_b = tsi_pkg::make_result(sk_key, sk_rec, p_nxt - sk_rec,
                                             sk_lines_inc, tsi_pkg::STATUS_OK);
            end
        end

        // end of file: drop all file state, next byte opens a new file
        if (i_last) begin
            n_mode      = MODE_MARK;
            n_held      = 2'd0;
            n_pos       = '0;
            n_rec_start = '0;
            n_cur_key   = '0;
            n_id_acc    = '0;
            n_id_seen   = 1'b0;
            n_at_head   = 1'b1;
            n_lines     = '0;
            n_line_idx  = '0;
            n_head_off  = '0;
        end
    end

    // pack: group result first, then the other one
    always_comb begin
        o_emit = '0;
        if (va) begin
            o_emit.v0          = i_advance;
            o_emit.r0          = res_a;
            o_emit.r0.last_run = !vb;
            o_emit.v1          = i_advance && vb;
            o_emit.r1          = res_b;
            o_emit.r1.last_run = 1'b1;
        end else begin
            o_emit.v0          = i_advance && vb;
            o_emit.r0          = res_b;
            o_emit.r0.last_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_MARK;
            r_held      <= 2'd0;
            r_pos       <= '0;
            r_rec_start <= '0;
            r_cur_key   <= '0;
            r_id_acc    <= '0;
            r_id_seen   <= 1'b0;
            r_at_head   <= 1'b1;
            r_lines     <= '0;
            r_line_idx  <= '0;
            r_head_off  <= '0;
        end else if (i_advance) begin
            r_mode      <= n_mode;
            r_held      <= n_held;
            r_pos       <= n_pos;
            r_rec_start <= n_rec_start;
            r_cur_key   <= n_cur_key;
            r_id_acc    <= n_id_acc;
            r_id_seen   <= n_id_seen;
            r_at_head   <= n_at_head;
            r_lines     <= n_lines;
            r_line_idx  <= n_line_idx;
            r_head_off  <= n_head_off;
        end
    end

    a_held_only_in_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != 2'd0) |-> (r_mode == MODE_MARK))
        else $error("mark prefix held outside mark check");

    a_last_restarts_file: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_last) |=> (r_mode == MODE_MARK && r_pos == '0))
        else $error("file state not cleared after last byte");

endmodule

`default_nettype wire

/* hdl/tsi_out_fifo.sv */
// Four-entry result queue: takes up to two results a cycle, hands out one per beat unless the output stalls.
// Depends on tsi_pkg for t_result, t_emit and the queue sizes.
`default_nettype none

module tsi_out_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tsi_pkg::t_emit i_emit,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output tsi_pkg::t_result   o_head,
    output logic               o_space
);

    localparam int DEPTH = tsi_pkg::FIFO_DEPTH;
    localparam int PW    = tsi_pkg::FIFO_PTR_W;
    localparam int CW    = tsi_pkg::FIFO_CNT_W;

    tsi_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [PW-1:0]    wr_ptr_1;
    logic [CW-1:0]    push_n;
    logic             pop;

    assign o_out_valid = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign o_space     = (r_count <= CW'(DEPTH - 2));
    assign pop         = o_out_valid && !i_out_stall;
    assign push_n      = CW'(i_emit.v0) + CW'(i_emit.v1);
    assign wr_ptr_1    = r_wr_ptr + PW'(1);
    assign n_count     = r_count + push_n - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (i_emit.v0) begin
            r_mem[r_wr_ptr] <= i_emit.r0;
        end
        if (i_emit.v1) begin
            r_mem[wr_ptr_1] <= i_emit.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PW'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overfilled");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_emit.v0 || i_emit.v1) |-> o_space)
        else $error("results pushed without room for two");

    a_second_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_emit.v1 |-> (i_emit.v0 && i_emit.r1.last_run && !i_emit.r0.last_run))
        else $error("second result without a first");

endmodule

`default_nettype wire

/* hdl/text_sequence_indexer_unit.sv */
// Top level of the text sequence indexer: input register, mode register,
// parser and result queue. Depends on tsi_pkg, tsi_parse and tsi_out_fifo.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_data_byte, i_last_byte
//  out     | source    | o_out_valid / i_out_stall | o_record_key .. o_last_of_run
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_data (use_sequence_ids)
//
// One byte per cycle while the input is not stalled: a byte is registered in the input
// register, then the parser updates its state and pushes zero, one or two results into a
// four-entry queue; the first result is visible the cycle after that.
// The input stalls only while the queue cannot take two more results.
// Synchronous active-low reset; the mode register resets to 1 (ids mode).
`default_nettype none

module text_sequence_indexer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_record_key,
    output logic [31:0]      o_start_offset,
    output logic [31:0]      o_byte_count,
    output logic [31:0]      o_line_count,
    output logic             o_status,
    output logic             o_last_of_run,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             r_use_ids;
    logic             in_accept;
    logic             advance;
    logic             space;
    tsi_pkg::t_emit   emit;
    tsi_pkg::t_result head;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && space;
    assign o_in_stall  = r_in_valid && !space;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_use_ids  <= 1'b1;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
            if (i_cfg_valid && o_cfg_ready) begin
                r_use_ids <= i_cfg_data;
            end
        end
    end

    // hold the beat until the parser takes it
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    tsi_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_use_ids (r_use_ids),
        .o_emit    (emit)
    );

    tsi_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (emit),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_head      (head),
        .o_space     (space)
    );

    assign o_record_key   = head.key;
    assign o_start_offset = head.start;
    assign o_byte_count   = head.size;
    assign o_line_count   = head.lines;
    assign o_status       = head.status;
    assign o_last_of_run  = head.last_run;

endmodule

`default_nettype wire
